### rtl/oese_pkg.sv
// Octal escape stream encoder: shared types and character constants.
// Used by oese_front, oese_back and the top level; no dependencies.
package oese_pkg;

    localparam int QUEUE_DEPTH = 2;   // command queue entries, power of two, >= 2
    localparam int MAX_OUT     = 6;   // most output bytes one request can cause

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_0   = 8'h30;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // One queued command: an optional octal escape of the held byte, then
    // zero to two literal bytes for the new byte.
    typedef struct packed {
        logic       esc_vld;
        logic [7:0] esc_byte;
        logic       esc_pad3;
        logic [1:0] tail_len;
        logic [7:0] tail_b0;
        logic [7:0] tail_b1;
    } t_cmd;

endpackage

### rtl/oese_fifo.sv
// Small register queue between front and back of the encoder.
// Generic width/depth; no package dependencies.
module oese_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

### rtl/oese_front.sv
// Front end: accepts requests, keeps the held byte, classifies each byte
// into a queue command. Depends on oese_pkg.
module oese_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_action,
    input  logic [7:0]       i_byte_value,
    input  logic             i_full,
    output logic             o_push,
    output oese_pkg::t_cmd   o_cmd
);
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte,  n_held_byte;
    logic       accept;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic passes(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h2F, 8'h2E, 8'h5F};
    endfunction

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.esc_vld  = r_held_valid;
        o_cmd.esc_byte = r_held_byte;
        // padding only means something for a byte that is actually held
        o_cmd.esc_pad3 = r_held_valid && (i_action == oese_pkg::ACT_DATA) &&
                         is_digit(i_byte_value);
        n_held_valid   = 1'b0;
        n_held_byte    = '0;
        if (i_action == oese_pkg::ACT_DATA) begin
            case (i_byte_value)
                oese_pkg::CH_NUL: begin
                    o_cmd.tail_len = 2'd1;
                    o_cmd.tail_b0  = oese_pkg::CH_LF;
                end
                oese_pkg::CH_LF: begin
                    o_cmd.tail_len = 2'd2;
                    o_cmd.tail_b0  = oese_pkg::CH_ESC;
                    o_cmd.tail_b1  = oese_pkg::CH_N;
                end
                oese_pkg::CH_TAB: begin
                    o_cmd.tail_len = 2'd2;
                    o_cmd.tail_b0  = oese_pkg::CH_ESC;
                    o_cmd.tail_b1  = oese_pkg::CH_T;
                end
                oese_pkg::CH_CR: begin
                    o_cmd.tail_len = 2'd2;
                    o_cmd.tail_b0  = oese_pkg::CH_ESC;
                    o_cmd.tail_b1  = oese_pkg::CH_R;
                end
                oese_pkg::CH_ESC: begin
                    o_cmd.tail_len = 2'd2;
                    o_cmd.tail_b0  = oese_pkg::CH_ESC;
                    o_cmd.tail_b1  = oese_pkg::CH_ESC;
                end
                default: begin
                    if (passes(i_byte_value)) begin
                        o_cmd.tail_len = 2'd1;
                        o_cmd.tail_b0  = i_byte_value;
                    end else begin
                        // needs octal: wait to see what follows
                        n_held_valid = 1'b1;
                        n_held_byte  = i_byte_value;
                    end
                end
            endcase
        end
    end

    // empty commands (nothing flushed, no literal bytes) are not queued
    assign o_push = accept && (o_cmd.esc_vld || (o_cmd.tail_len != 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
        end else if (accept) begin
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
        end
    end

endmodule

### rtl/oese_back.sv
// Back end: expands one queue command into output bytes and shifts them
// out through the output register. Depends on oese_pkg.
module oese_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  oese_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    localparam int NB = oese_pkg::MAX_OUT;
    localparam int CW = $clog2(NB + 1);

    logic [7:0]    r_buf [NB];
    logic [CW-1:0] r_cnt;
    logic [7:0]    lst [NB];
    logic [7:0]    esc [4];
    logic [CW-1:0] elen, len;
    logic [1:0]    ndig;
    logic [7:0]    v;
    logic          take;

    always_comb begin
        v = i_cmd.esc_byte;
        if (i_cmd.esc_pad3 || (v >= 8'd64)) ndig = 2'd3;
        else if (v >= 8'd8)                 ndig = 2'd2;
        else                                ndig = 2'd1;
        esc[0] = oese_pkg::CH_ESC;
        esc[1] = '0;
        esc[2] = '0;
        esc[3] = '0;
        case (ndig)
            2'd3: begin
                esc[1] = oese_pkg::CH_0 + {6'd0, v[7:6]};
                esc[2] = oese_pkg::CH_0 + {5'd0, v[5:3]};
                esc[3] = oese_pkg::CH_0 + {5'd0, v[2:0]};
            end
            2'd2: begin
                esc[1] = oese_pkg::CH_0 + {5'd0, v[5:3]};
                esc[2] = oese_pkg::CH_0 + {5'd0, v[2:0]};
            end
            default: begin
                esc[1] = oese_pkg::CH_0 + {5'd0, v[2:0]};
            end
        endcase
        elen = i_cmd.esc_vld ? (CW'(ndig) + CW'(1)) : '0;
        len  = elen + CW'(i_cmd.tail_len);
        for (int i = 0; i < NB; i++) begin
            if (CW'(i) < elen)       lst[i] = esc[i % 4];
            else if (CW'(i) == elen) lst[i] = i_cmd.tail_b0;
            else                     lst[i] = i_cmd.tail_b1;
        end
    end

    assign o_valid    = (r_cnt != '0);
    assign o_out_byte = r_buf[0];
    assign o_out_last = (r_cnt == CW'(1));
    assign take       = o_valid && !i_stall;
    // reload in the same cycle the last byte leaves
    assign o_pop      = !i_empty && (!o_valid || (o_out_last && take));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_pop) begin
            r_cnt <= len;
        end else if (take) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buf <= lst;
        end else if (take) begin
            for (int i = 0; i < NB - 1; i++) r_buf[i] <= r_buf[i + 1];
        end
    end

endmodule

### rtl/octal_escape_stream_encoder.sv
// Top level of the octal escape stream encoder.
// Instantiates oese_front, oese_fifo and oese_back; uses oese_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall, i_action, i_byte_value): one request per
//   byte, or an end request (i_action = 1) that flushes a held octal escape.
//   Output channel (o_valid / i_stall, o_out_byte, o_out_last): encoded
//   ASCII bytes, one per cycle unless stalled; o_out_last marks the last byte
//   caused by a request. A byte that needs octal is held in the front until
//   the next request, which decides between three-digit and minimal form;
//   such a request by itself produces no output.
// Data path: the front writes an accepted request's command into the queue,
//   then the back loads it into its output shift register, which drives it out.
// Throughput: the front takes one request per cycle while the queue has room;
//   unstalled, the back emits one byte per cycle, 0 to 6 per request (none
//   when a byte is only held); the output shift line sets the sustained rate.
// Stall: a stalled receiver freezes the output byte; the queue fills and
//   o_stall rises only when it is full.
// Reset (synchronous, active low): drops any held byte, empties the queue
//   and the output register.
module octal_escape_stream_encoder #(
    parameter int QUEUE_DEPTH = oese_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    localparam int CMD_W = $bits(oese_pkg::t_cmd);

    oese_pkg::t_cmd push_cmd, pop_cmd;
    logic           push, pop, full, empty;
    logic [CMD_W-1:0] pop_data;

    oese_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    oese_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    assign pop_cmd = oese_pkg::t_cmd'(pop_data);

    oese_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (pop_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full)) else $error("command pushed into full queue");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty)) else $error("command popped from empty queue");

    // three-digit padding only applies to an actually held byte
    a_pad_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_cmd.esc_pad3) |-> push_cmd.esc_vld)
        else $error("padding requested with no held byte");

    // a queued command always yields at least one output byte
    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_cmd.esc_vld || (push_cmd.tail_len != 2'd0)))
        else $error("empty command queued");

endmodule

### dv/oese_escape_checker.sv
// Checker for the octal escape stream encoder: it encodes every accepted request
// and compares the block's output bytes with the expected ones, oldest first.
// Depends on oese_pkg for the action codes and the character constants.
module oese_escape_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_byte_value,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    t_enc_byte  expected_bytes[$];
    logic [7:0] run_bytes[$];
    logic       held_vld;
    logic [7:0] held_val;
    int         fails;

    initial begin
        fails        = 0;
        held_vld     = 1'b0;
        held_val     = 8'h00;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // Letters, digits, '/', '.' and '_' go through untouched.
    function automatic bit is_plain(input logic [7:0] b);
        return is_digit(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               b == 8'h2F || b == 8'h2E || b == 8'h5F;
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        if (fails <= 100) begin
            $display("oese checker: %s", what);
        end
    endtask

    task automatic add_octal(input logic [7:0] v, input bit pad3);
        run_bytes.push_back(oese_pkg::CH_ESC);
        if (pad3 || v >= 8'd64) begin
            run_bytes.push_back(oese_pkg::CH_0 + {6'd0, v[7:6]});
        end
        if (pad3 || v >= 8'd8) begin
            run_bytes.push_back(oese_pkg::CH_0 + {5'd0, v[5:3]});
        end
        run_bytes.push_back(oese_pkg::CH_0 + {5'd0, v[2:0]});
    endtask

    task automatic encode_request(input logic act, input logic [7:0] b);
        run_bytes.delete();
        if (act == oese_pkg::ACT_END) begin
            if (held_vld) begin
                add_octal(held_val, 1'b0);
            end
            held_vld = 1'b0;
            held_val = 8'h00;
        end else begin
            if (held_vld) begin
                add_octal(held_val, is_digit(b));
                held_vld = 1'b0;
                held_val = 8'h00;
            end
            case (b)
                oese_pkg::CH_NUL: run_bytes.push_back(oese_pkg::CH_LF);
                oese_pkg::CH_LF: begin
                    run_bytes.push_back(oese_pkg::CH_ESC);
                    run_bytes.push_back(oese_pkg::CH_N);
                end
                oese_pkg::CH_TAB: begin
                    run_bytes.push_back(oese_pkg::CH_ESC);
                    run_bytes.push_back(oese_pkg::CH_T);
                end
                oese_pkg::CH_CR: begin
                    run_bytes.push_back(oese_pkg::CH_ESC);
                    run_bytes.push_back(oese_pkg::CH_R);
                end
                oese_pkg::CH_ESC: begin
                    run_bytes.push_back(oese_pkg::CH_ESC);
                    run_bytes.push_back(oese_pkg::CH_ESC);
                end
                default: begin
                    if (is_plain(b)) begin
                        run_bytes.push_back(b);
                    end else begin
                        held_vld = 1'b1;
                        held_val = b;
                    end
                end
            endcase
        end
        foreach (run_bytes[k]) begin
            expected_bytes.push_back({run_bytes[k], k == run_bytes.size() - 1});
        end
    endtask

    always @(posedge i_clk) begin
        t_enc_byte exp_b;
        if (!i_rst_n) begin
            expected_bytes.delete();
            held_vld = 1'b0;
            held_val = 8'h00;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                              i_out_byte, i_out_last));
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (i_out_byte !== exp_b.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out_byte, exp_b.data));
                    end
                    if (i_out_last !== exp_b.last) begin
                        report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                                  i_out_last, exp_b.last, exp_b.data));
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                encode_request(i_action, i_byte_value);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
    end

endmodule

### dv/testbench.sv
// Top of the octal escape stream encoder testbench: clock, reset, request
// stimulus and output back-pressure; checking is done by oese_escape_checker.
// Depends on oese_pkg, octal_escape_stream_encoder and oese_escape_checker.
module testbench;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_action;
    logic [7:0] i_byte_value;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    int fail_count;
    int pending;

    // Coordination between the request side and the output side.
    bit hold_req;    // receiver should hold off for a long stretch
    bit burst;       // no idling on either side
    int hold_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    octal_escape_stream_encoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

    oese_escape_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one request. Random idle cycles go in front of it unless we are
    // in the burst stretch; valid stays high straight into the next request
    // when no idle is drawn, so it is never dropped and raised in one step.
    task automatic send_req(input logic act, input logic [7:0] b);
        while (!burst && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_byte_value <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Byte mix leaning toward the interesting classes: digits right after a
    // held byte decide the three-digit form, so they come up often.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return oese_pkg::CH_0 + 8'($urandom_range(0, 9));
        end else if (r < 33) begin
            return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                               : 8'($urandom_range(8'h61, 8'h7A));
        end else if (r < 40) begin
            case ($urandom_range(0, 2))
                0:       return 8'h2F;
                1:       return 8'h2E;
                default: return 8'h5F;
            endcase
        end else if (r < 52) begin
            case ($urandom_range(0, 4))
                0:       return oese_pkg::CH_NUL;
                1:       return oese_pkg::CH_LF;
                2:       return oese_pkg::CH_TAB;
                3:       return oese_pkg::CH_CR;
                default: return oese_pkg::CH_ESC;
            endcase
        end else begin
            // full range: mostly bytes that need octal, every bit toggles
            return 8'($urandom_range(0, 255));
        end
    endfunction

    // Output side: random stalls, one long hold-off on request, and none
    // at all during the burst stretch.
    initial begin
        i_stall   = 1'b0;
        hold_left = 64;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (burst) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 37);
            end
        end
    end

    // Request side and verdict.
    initial begin
        int guard;
        i_valid      = 1'b0;
        i_action     = oese_pkg::ACT_DATA;
        i_byte_value = 8'h00;
        i_rst_n      = 1'b0;
        hold_req     = 1'b0;
        burst        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pass-through classes and the extremes.
        send_req(oese_pkg::ACT_DATA, 8'h41);
        send_req(oese_pkg::ACT_DATA, 8'h7A);
        send_req(oese_pkg::ACT_DATA, 8'h30);
        send_req(oese_pkg::ACT_DATA, 8'h39);
        send_req(oese_pkg::ACT_DATA, 8'h2F);
        send_req(oese_pkg::ACT_DATA, 8'h2E);
        send_req(oese_pkg::ACT_DATA, 8'h5F);
        // NUL turns into a newline; the four two-character escapes
        send_req(oese_pkg::ACT_DATA, oese_pkg::CH_NUL);
        send_req(oese_pkg::ACT_DATA, oese_pkg::CH_LF);
        send_req(oese_pkg::ACT_DATA, oese_pkg::CH_TAB);
        send_req(oese_pkg::ACT_DATA, oese_pkg::CH_CR);
        send_req(oese_pkg::ACT_DATA, oese_pkg::CH_ESC);
        // held byte followed by a digit: padded to three digits
        send_req(oese_pkg::ACT_DATA, 8'hFF);
        send_req(oese_pkg::ACT_DATA, 8'h35);
        // held byte followed by a letter: minimal digits
        send_req(oese_pkg::ACT_DATA, 8'h01);
        send_req(oese_pkg::ACT_DATA, 8'h61);
        // end flushes a held byte; a second end has nothing to flush
        send_req(oese_pkg::ACT_DATA, 8'h07);
        send_req(oese_pkg::ACT_END, 8'hA5);
        send_req(oese_pkg::ACT_END, 8'h5A);
        // held byte replaced by another held byte, then padded zeros
        send_req(oese_pkg::ACT_DATA, 8'h80);
        send_req(oese_pkg::ACT_DATA, 8'h01);
        send_req(oese_pkg::ACT_DATA, 8'h30);
        // chain of held bytes ending with a flush
        send_req(oese_pkg::ACT_DATA, 8'h08);
        send_req(oese_pkg::ACT_DATA, 8'h3F);
        send_req(oese_pkg::ACT_DATA, 8'h20);
        send_req(oese_pkg::ACT_END, 8'hFF);

        // Random part: mostly data bytes, about one in ten an end request.
        for (int n = 0; n < 155; n++) begin
            if (n == 50) begin
                hold_req = 1'b1;          // receiver backs off; queue fills up
            end
            if (n == 100) begin
                burst = 1'b1;
            end
            if (n == 130) begin
                burst = 1'b0;
            end
            if (n == 150) begin
                // let everything drain before carrying on
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) begin
                    @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 99) < 10) begin
                send_req(oese_pkg::ACT_END, 8'($urandom_range(0, 255)));
            end else begin
                send_req(oese_pkg::ACT_DATA, pick_byte());
            end
        end
        i_valid <= 1'b0;

        // Drain, then a few more cycles to catch stray output bytes.
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[octal_escape_stream_encoder] OK");
        end else begin
            $display("[octal_escape_stream_encoder] ERROR");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("[octal_escape_stream_encoder] ERROR");
        $finish;
    end

endmodule
